// File: sv/dsrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual-slot record selector package
// Shared types, reset values, register indexes and the CRC-32 word update.
// ----------------------------------------------------------------------------
package dsrs_pkg;

  localparam logic [31:0] CRC_POLY       = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES       = 32'hFFFFFFFF;
  localparam logic [31:0] MAGIC_RST      = 32'h324C4143;
  localparam logic [31:0] COMMIT_RST     = 32'hA55A3CC3;
  localparam logic [31:0] SCHEMA_RST     = 32'd1;
  localparam logic [5:0]  PAYLOAD_RST    = 6'd16;
  localparam logic [5:0]  SCHEMA_IDX_RST = 6'd0;
  localparam logic [5:0]  PAYLOAD_MIN    = 6'd1;
  localparam logic [5:0]  PAYLOAD_MAX    = 6'd58;

  typedef enum logic [2:0] {
    CFG_MAGIC      = 3'd0,
    CFG_COMMIT     = 3'd1,
    CFG_SCHEMA     = 3'd2,
    CFG_PAYLOAD    = 3'd3,
    CFG_SCHEMA_IDX = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] magic_word;
    logic [31:0] commit_word;
    logic [31:0] schema_id;
    logic [5:0]  payload_words;
    logic [5:0]  schema_word_index;
  } cfg_t;

  // Event handed from the front end to the slot tracker.
  typedef struct packed {
    logic        forget;
    logic        ok;
    logic        slot;
    logic [31:0] seq;
  } evt_t;

  // Reflected CRC-32 update over the four little-endian bytes of a word.
  function automatic logic [31:0] crc_word(logic [31:0] crc, logic [31:0] w);
    logic [31:0] c;
    c = crc ^ w;
    for (int k = 0; k < 32; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: sv/dsrs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual-slot record selector front end
// Tracks the word position, runs the CRC and field checks, and emits one
// event per commit word or forget command.
// ----------------------------------------------------------------------------
module dsrs_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dsrs_pkg::cfg_t   cfg_i,
  input  logic             fire_i,
  input  logic             command_i,
  input  logic             slot_i,
  input  logic             first_word_i,
  input  logic [31:0]      data_word_i,
  input  logic             read_error_i,
  output logic             evt_push_o,
  output dsrs_pkg::evt_t   evt_o
);

  localparam logic [5:0] POS_MAGIC  = 6'd0;
  localparam logic [5:0] POS_SCHEMA = 6'd1;
  localparam logic [5:0] POS_SEQ    = 6'd2;
  localparam logic [5:0] POS_SIZE   = 6'd3;
  localparam logic [5:0] HDR_WORDS  = 6'd4;

  logic [5:0]  wc_q, wc_d;
  logic [31:0] crc_q, crc_d;
  logic        pass_q, pass_d;
  logic        slot_q, slot_d;
  logic [31:0] seq_q, seq_d;
  logic [31:0] crc_cap_q, crc_cap_d;

  logic        restart;
  logic [5:0]  base_wc;
  logic [31:0] base_crc;
  logic        base_pass;
  logic        base_slot;
  logic [5:0]  p_eff;
  logic [6:0]  crc_end;
  logic [6:0]  pos7;
  logic [31:0] crc_next;
  logic        pass_n;
  logic        chk;
  logic        ok;

  always_comb begin
    restart   = first_word_i | (wc_q == '0);
    base_wc   = restart ? '0 : wc_q;
    base_crc  = restart ? dsrs_pkg::CRC_ONES : crc_q;
    base_pass = restart | pass_q;
    base_slot = restart ? slot_i : slot_q;
    if (cfg_i.payload_words < dsrs_pkg::PAYLOAD_MIN) begin
      p_eff = dsrs_pkg::PAYLOAD_MIN;
    end else if (cfg_i.payload_words > dsrs_pkg::PAYLOAD_MAX) begin
      p_eff = dsrs_pkg::PAYLOAD_MAX;
    end else begin
      p_eff = cfg_i.payload_words;
    end
    crc_end  = {1'b0, p_eff} + {1'b0, HDR_WORDS};
    pos7     = {1'b0, base_wc};
    crc_next = dsrs_pkg::crc_word(base_crc, data_word_i);
    pass_n   = base_pass & ~read_error_i;

    wc_d       = wc_q;
    crc_d      = crc_q;
    pass_d     = pass_q;
    slot_d     = slot_q;
    seq_d      = seq_q;
    crc_cap_d  = crc_cap_q;
    chk        = 1'b1;
    ok         = 1'b0;
    evt_push_o = 1'b0;
    evt_o      = '{forget: 1'b0, ok: 1'b0, slot: base_slot, seq: seq_q};

    if (fire_i) begin
      if (command_i) begin
        wc_d         = '0;
        crc_d        = dsrs_pkg::CRC_ONES;
        pass_d       = 1'b1;
        evt_push_o   = 1'b1;
        evt_o.forget = 1'b1;
      end else begin
        wc_d   = base_wc + 6'd1;
        crc_d  = (pos7 < crc_end) ? crc_next : base_crc;
        slot_d = base_slot;
        priority if (base_wc == POS_MAGIC) begin
          chk = (data_word_i == cfg_i.magic_word);
        end else if (base_wc == POS_SCHEMA) begin
          chk = (data_word_i == cfg_i.schema_id);
        end else if (base_wc == POS_SEQ) begin
          seq_d = data_word_i;
        end else if (base_wc == POS_SIZE) begin
          chk = (data_word_i == {24'd0, p_eff, 2'b00});
        end else if (pos7 < crc_end) begin
          chk = !(((base_wc - HDR_WORDS) == cfg_i.schema_word_index) &&
                  (data_word_i != cfg_i.schema_id));
        end else if (pos7 == crc_end) begin
          crc_cap_d = data_word_i;
        end else begin
          ok = pass_n && (data_word_i == cfg_i.commit_word) &&
               ((base_crc ^ dsrs_pkg::CRC_ONES) == crc_cap_q) &&
               (cfg_i.schema_word_index < p_eff);
          wc_d       = '0;
          evt_push_o = 1'b1;
          evt_o.ok   = ok;
        end
        pass_d = pass_n & chk;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wc_q      <= '0;
      crc_q     <= dsrs_pkg::CRC_ONES;
      pass_q    <= 1'b1;
      slot_q    <= 1'b0;
      seq_q     <= '0;
      crc_cap_q <= '0;
    end else begin
      wc_q      <= wc_d;
      crc_q     <= crc_d;
      pass_q    <= pass_d;
      slot_q    <= slot_d;
      seq_q     <= seq_d;
      crc_cap_q <= crc_cap_d;
    end
  end

endmodule

// File: sv/dsrs_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual-slot record selector event queue
// Short queue of events between the front end and the slot tracker.
// ----------------------------------------------------------------------------
module dsrs_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dsrs_pkg::evt_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output dsrs_pkg::evt_t data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  dsrs_pkg::evt_t    mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: sv/dsrs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual-slot record selector slot tracker
// Applies events to the two slot records and registers the selection report.
// ----------------------------------------------------------------------------
module dsrs_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           evt_valid_i,
  input  dsrs_pkg::evt_t evt_i,
  output logic           evt_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           record_passed_o,
  output logic [1:0]     valid_mask_o,
  output logic           have_newest_o,
  output logic           newest_slot_o,
  output logic [31:0]    newest_sequence_o,
  output logic           save_slot_o,
  output logic [31:0]    target_sequence_o
);

  logic [1:0]  ok_q, ok_d;
  logic [31:0] seq_q [2];
  logic [31:0] seq_d [2];
  logic        out_valid_q, out_valid_d;
  logic        rec_valid_q, rec_valid_d;
  logic        have_q, have_d;
  logic        ns_q, ns_d;
  logic [31:0] nq_q, nq_d;
  logic        ts_q, ts_d;
  logic [31:0] tq_q, tq_d;
  logic [31:0] diff;

  assign evt_pop_o = evt_valid_i & (~out_valid_q | out_ready_i);

  always_comb begin
    ok_d     = ok_q;
    seq_d[0] = seq_q[0];
    seq_d[1] = seq_q[1];
    if (evt_i.forget) begin
      ok_d     = 2'b00;
      seq_d[0] = '0;
      seq_d[1] = '0;
    end else begin
      ok_d[evt_i.slot] = evt_i.ok;
      if (evt_i.ok) begin
        seq_d[evt_i.slot] = evt_i.seq;
      end
    end

    diff   = seq_d[0] - seq_d[1];
    have_d = ok_d[0] | ok_d[1];
    priority if (ok_d[0] && ok_d[1]) begin
      ns_d = !((diff != '0) && !diff[31]);
    end else if (ok_d[0]) begin
      ns_d = 1'b0;
    end else begin
      ns_d = ok_d[1];
    end
    nq_d        = have_d ? seq_d[ns_d] : '0;
    ts_d        = have_d & ~ns_d;
    tq_d        = have_d ? (seq_d[ns_d] + 32'd1) : 32'd1;
    rec_valid_d = ~evt_i.forget & evt_i.ok;

    out_valid_d = out_valid_q;
    if (evt_pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q        <= 2'b00;
      seq_q[0]    <= '0;
      seq_q[1]    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (evt_pop_o) begin
        ok_q     <= ok_d;
        seq_q[0] <= seq_d[0];
        seq_q[1] <= seq_d[1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_pop_o) begin
      rec_valid_q <= rec_valid_d;
      have_q      <= have_d;
      ns_q        <= ns_d;
      nq_q        <= nq_d;
      ts_q        <= ts_d;
      tq_q        <= tq_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign record_passed_o   = rec_valid_q;
  assign valid_mask_o      = ok_q;
  assign have_newest_o     = have_q;
  assign newest_slot_o     = ns_q;
  assign newest_sequence_o = nq_q;
  assign save_slot_o       = ts_q;
  assign target_sequence_o = tq_q;

  a_valid_has_newest : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && rec_valid_q |-> have_q)
    else $error("valid record reported without a newest slot");

  a_have_matches_mask : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (have_q == (ok_q != 2'b00)))
    else $error("have_newest disagrees with valid mask");

  a_empty_report : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !have_q |-> (tq_q == 32'd1) && (nq_q == '0))
    else $error("empty report carries wrong sequences");

  a_target_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && have_q |-> (tq_q == nq_q + 32'd1) && (ts_q != ns_q))
    else $error("target does not follow newest");

  a_forget_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_pop_o && evt_i.forget |=> (ok_q == 2'b00) && !rec_valid_q)
    else $error("forget did not clear both slots");

endmodule

// File: sv/dual_slot_record_selector_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual-slot record selector
// Checks records read back from two flash slots and reports the newest
// valid slot and the target of the next save.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle when the queue is not full (whole-word CRC).
// Report path: a commit word or forget transfer queues an event, which the slot
// tracker pops and registers as a report once its output register is free or read.
// Reset: both slots invalid with sequence zero, CRC state all ones, and the
// configuration registers return to their default values.
// ----------------------------------------------------------------------------
module dual_slot_record_selector_top #(
  parameter int unsigned FIFO_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic        slot_i,
  input  logic        first_word_i,
  input  logic [31:0] data_word_i,
  input  logic        read_error_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        record_passed_o,
  output logic [1:0]  valid_mask_o,
  output logic        have_newest_o,
  output logic        newest_slot_o,
  output logic [31:0] newest_sequence_o,
  output logic        save_slot_o,
  output logic [31:0] target_sequence_o
);

  dsrs_pkg::cfg_t cfg_q, cfg_d;
  dsrs_pkg::evt_t push_evt;
  dsrs_pkg::evt_t pop_evt;
  logic           push;
  logic           full;
  logic           pop;
  logic           evt_valid;
  logic           in_fire;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = ~full;
  assign in_fire     = in_valid_i & in_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        dsrs_pkg::CFG_MAGIC:      cfg_d.magic_word        = cfg_data_i;
        dsrs_pkg::CFG_COMMIT:     cfg_d.commit_word       = cfg_data_i;
        dsrs_pkg::CFG_SCHEMA:     cfg_d.schema_id         = cfg_data_i;
        dsrs_pkg::CFG_PAYLOAD:    cfg_d.payload_words     = cfg_data_i[5:0];
        dsrs_pkg::CFG_SCHEMA_IDX: cfg_d.schema_word_index = cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic_word        <= dsrs_pkg::MAGIC_RST;
      cfg_q.commit_word       <= dsrs_pkg::COMMIT_RST;
      cfg_q.schema_id         <= dsrs_pkg::SCHEMA_RST;
      cfg_q.payload_words     <= dsrs_pkg::PAYLOAD_RST;
      cfg_q.schema_word_index <= dsrs_pkg::SCHEMA_IDX_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  dsrs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .fire_i       (in_fire),
    .command_i    (command_i),
    .slot_i       (slot_i),
    .first_word_i (first_word_i),
    .data_word_i  (data_word_i),
    .read_error_i (read_error_i),
    .evt_push_o   (push),
    .evt_o        (push_evt)
  );

  dsrs_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_evt),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (evt_valid),
    .data_o  (pop_evt)
  );

  dsrs_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .evt_valid_i       (evt_valid),
    .evt_i             (pop_evt),
    .evt_pop_o         (pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .record_passed_o   (record_passed_o),
    .valid_mask_o      (valid_mask_o),
    .have_newest_o     (have_newest_o),
    .newest_slot_o     (newest_slot_o),
    .newest_sequence_o (newest_sequence_o),
    .save_slot_o       (save_slot_o),
    .target_sequence_o (target_sequence_o)
  );

endmodule
